// ===== src/kft_pkg.sv =====
// Shared types and constants of the keyframe tangent unit.
`timescale 1ns / 1ps
`default_nettype none
package kft_pkg;

   localparam logic [1:0] MODE_SMOOTH = 2'd0;
   localparam logic [1:0] MODE_LINEAR = 2'd1;
   localparam logic [1:0] MODE_CONST  = 2'd2;

   localparam logic [3:0] CODE_AUTO   = 4'd4;
   localparam logic [3:0] CODE_LINEAR = 4'd2;
   localparam logic [3:0] CODE_CONST  = 4'd3;

   localparam logic [31:0] TAN_INF = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [31:0] older_time;
      logic [31:0] older_value;
      logic [31:0] newer_time;
      logic [31:0] newer_value;
      logic [31:0] cur_time;
      logic [31:0] cur_value;
      logic [1:0]  keys_seen;
      logic        last;
      logic [1:0]  mode;
   } task_type;

endpackage
`default_nettype wire

// ===== src/kft_front.sv =====
// Front end: accepts keyframe words, keeps the key window and builds tasks.
`timescale 1ns / 1ps
`default_nettype none
module kft_front
   import kft_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wen,
   input  wire logic [1:0]  csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        q_ready,
   output logic             q_push,
   output task_type         q_task
);

   logic [1:0]  mode_ff, mode_in;
   logic [31:0] older_time_ff, older_time_in, older_value_ff, older_value_in;
   logic [31:0] newer_time_ff, newer_time_in, newer_value_ff, newer_value_in;
   logic [1:0]  keys_seen_ff, keys_seen_in;

   always_comb begin
      req_tready = q_ready;
      q_push = req_tvalid && q_ready;
      q_task.older_time = older_time_ff;
      q_task.older_value = older_value_ff;
      q_task.newer_time = newer_time_ff;
      q_task.newer_value = newer_value_ff;
      q_task.cur_time = req_tdata[31:0];
      q_task.cur_value = req_tdata[63:32];
      q_task.keys_seen = keys_seen_ff;
      q_task.last = req_tlast;
      q_task.mode = mode_ff;

      mode_in = csr_wen ? csr_wdata : mode_ff;
      older_time_in = older_time_ff;
      older_value_in = older_value_ff;
      newer_time_in = newer_time_ff;
      newer_value_in = newer_value_ff;
      keys_seen_in = keys_seen_ff;
      if (q_push) begin
         older_time_in = newer_time_ff;
         older_value_in = newer_value_ff;
         newer_time_in = req_tdata[31:0];
         newer_value_in = req_tdata[63:32];
         if (req_tlast) begin
            keys_seen_in = 2'd0;
         end else if (keys_seen_ff != 2'd2) begin
            keys_seen_in = keys_seen_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SMOOTH;
         older_time_ff <= '0;
         older_value_ff <= '0;
         newer_time_ff <= '0;
         newer_value_ff <= '0;
         keys_seen_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         older_time_ff <= older_time_in;
         older_value_ff <= older_value_in;
         newer_time_ff <= newer_time_in;
         newer_value_ff <= newer_value_in;
         keys_seen_ff <= keys_seen_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/kft_queue.sv =====
// Two-entry task queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module kft_queue
   import kft_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire task_type push_task,
   output logic          ready,
   output logic          valid,
   output task_type      head,
   input  wire logic     pop
);

   task_type   mem_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      ready = (count_ff != 2'd2);
      valid = (count_ff != 2'd0);
      head = mem_ff[rptr_ff];
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_task;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/kft_back.sv =====
// Back end: tangent evaluation on a shared divider and the result register.
`timescale 1ns / 1ps
`default_nettype none
module kft_back
   import kft_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   input  wire task_type    q_head,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,
   output logic [9:0]       rsp_tuser,
   output logic             rsp_tlast
);

   localparam int NW = ((36 + FRAC_BITS + 1) / 2) * 2;
   localparam int CW = $clog2(NW / 2 + 1);
   localparam logic [52:0] LIM1 = 53'd1 << FRAC_BITS;
   localparam logic [52:0] LIM4 = 53'd4 << FRAC_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_DIFF, S_FLAGS, S_PLAN, S_DIV, S_FIX, S_EMIT
   } state_type;

   function automatic logic [33:0] mag34(input logic [33:0] v);
      return v[33] ? (~v + 34'd1) : v;
   endfunction

   function automatic logic tiny(input logic [33:0] m, input logic [52:0] lim);
      return ({19'd0, m} * 53'd100000) < lim;
   endfunction

   state_type         state_ff, state_in;
   logic              job_ff, job_in, step_ff, step_in;
   logic              hp_ff, hp_in, hn_ff, hn_in, lastj_ff, lastj_in;
   logic [32:0]       dx1_ff, dx1_in, dy1_ff, dy1_in, dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic [33:0]       dx_ff, dx_in, dy_ff, dy_in;
   logic              tdx1_ff, tdx1_in, tdx2_ff, tdx2_in, tdx_ff, tdx_in;
   logic              tdy4_ff, tdy4_in;
   logic [34:0]       rem_ff, rem_in;
   logic [NW-1:0]     quo_ff, quo_in;
   logic [33:0]       den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [31:0]       tin_ff, tin_in, tout_ff, tout_in;
   logic              ov_ff, ov_in;
   logic [63:0]       od_ff, od_in;
   logic [9:0]        ou_ff, ou_in;
   logic              ol_ff, ol_in;

   logic [31:0] pt, pv, kt, kv, nt, nv;
   logic        is_lin, is_const, go_div, smooth_ok, neg1, neg2, nz1, nz2;
   logic [35:0] num, num_mag, a1x4, adyx3;
   logic [33:0] den, ady;
   logic [34:0] r0, r1;
   logic [NW-1:0] q0;
   logic [31:0] sat;
   logic [3:0]  code;
   logic        out_free;

   always_comb begin
      is_lin = (q_head.mode == MODE_LINEAR);
      is_const = (q_head.mode == MODE_CONST);
      code = is_const ? CODE_CONST : (is_lin ? CODE_LINEAR : CODE_AUTO);
      out_free = !ov_ff || rsp_tready;

      if (!job_ff) begin
         pt = q_head.older_time;  pv = q_head.older_value;
         kt = q_head.newer_time;  kv = q_head.newer_value;
         nt = q_head.cur_time;    nv = q_head.cur_value;
      end else begin
         pt = q_head.newer_time;  pv = q_head.newer_value;
         kt = q_head.cur_time;    kv = q_head.cur_value;
         nt = '0;                 nv = '0;
      end

      nz1 = !tdx1_ff && (dy1_ff != '0);
      nz2 = !tdx2_ff && (dy2_ff != '0);
      neg1 = dy1_ff[32] ^ dx1_ff[32];
      neg2 = dy2_ff[32] ^ dx2_ff[32];
      smooth_ok = hp_ff && hn_ff && nz1 && nz2 && (neg1 == neg2);
      ady = mag34(dy_ff);
      a1x4 = {1'b0, mag34({dy1_ff[32], dy1_ff}), 1'b0} << 1;
      adyx3 = {2'b00, ady} + {1'b0, ady, 1'b0};

      go_div = 1'b0;
      num = '0;
      den = dx_ff;
      if (is_lin) begin
         if (!step_ff) begin
            go_div = hp_ff && !tdx1_ff;
            num = {{3{dy1_ff[32]}}, dy1_ff};
            den = {dx1_ff[32], dx1_ff};
         end else begin
            go_div = hn_ff && !tdx2_ff;
            num = {{3{dy2_ff[32]}}, dy2_ff};
            den = {dx2_ff[32], dx2_ff};
         end
      end else if (smooth_ok && !tdx_ff) begin
         priority if (a1x4 >= adyx3) begin
            go_div = 1'b1;
            num = tdy4_ff ? {{2{dy_ff[33]}}, dy_ff} : {dy2_ff[32], dy2_ff, 2'b00};
         end else if (a1x4 < {2'b00, ady}) begin
            go_div = !tdy4_ff;
            num = {dy1_ff[32], dy1_ff, 2'b00};
         end else begin
            go_div = 1'b1;
            num = {{2{dy_ff[33]}}, dy_ff};
         end
      end
      num_mag = num[35] ? (~num + 36'd1) : num;

      r0 = {rem_ff[33:0], quo_ff[NW-1]};
      q0 = quo_ff << 1;
      if (r0 >= {1'b0, den_ff}) begin
         r0 = r0 - {1'b0, den_ff};
         q0[0] = 1'b1;
      end
      r1 = {r0[33:0], q0[NW-1]};
      q0 = q0 << 1;
      if (r1 >= {1'b0, den_ff}) begin
         r1 = r1 - {1'b0, den_ff};
         q0[0] = 1'b1;
      end

      if (neg_ff) begin
         sat = (quo_ff > NW'(33'h0_8000_0000)) ? 32'h8000_0000 : (~quo_ff[31:0] + 32'd1);
      end else begin
         sat = (quo_ff > NW'(32'h7FFF_FFFF)) ? TAN_INF : quo_ff[31:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      job_in = job_ff;   step_in = step_ff;
      hp_in = hp_ff;     hn_in = hn_ff;     lastj_in = lastj_ff;
      dx1_in = dx1_ff;   dy1_in = dy1_ff;   dx2_in = dx2_ff;   dy2_in = dy2_ff;
      dx_in = dx_ff;     dy_in = dy_ff;
      tdx1_in = tdx1_ff; tdx2_in = tdx2_ff; tdx_in = tdx_ff;   tdy4_in = tdy4_ff;
      rem_in = rem_ff;   quo_in = quo_ff;   den_in = den_ff;   neg_in = neg_ff;
      cnt_in = cnt_ff;   tin_in = tin_ff;   tout_in = tout_ff;
      ov_in = ov_ff && !rsp_tready;
      od_in = od_ff;     ou_in = ou_ff;     ol_in = ol_ff;
      q_pop = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               if (q_head.keys_seen != 2'd0) begin
                  job_in = 1'b0;
                  state_in = S_DIFF;
               end else if (q_head.last) begin
                  job_in = 1'b1;
                  state_in = S_DIFF;
               end else begin
                  q_pop = 1'b1;
               end
            end
         end
         S_DIFF: begin
            dx1_in = {kt[31], kt} - {pt[31], pt};
            dy1_in = {kv[31], kv} - {pv[31], pv};
            dx2_in = {nt[31], nt} - {kt[31], kt};
            dy2_in = {nv[31], nv} - {kv[31], kv};
            hp_in = job_ff ? (q_head.keys_seen != 2'd0) : (q_head.keys_seen == 2'd2);
            hn_in = !job_ff;
            lastj_in = job_ff;
            state_in = S_FLAGS;
         end
         S_FLAGS: begin
            dx_in = {dx1_ff[32], dx1_ff} + {dx2_ff[32], dx2_ff};
            dy_in = {dy1_ff[32], dy1_ff} + {dy2_ff[32], dy2_ff};
            tdx1_in = tiny(mag34({dx1_ff[32], dx1_ff}), LIM1);
            tdx2_in = tiny(mag34({dx2_ff[32], dx2_ff}), LIM1);
            tdx_in = tiny(mag34({dx1_ff[32], dx1_ff} + {dx2_ff[32], dx2_ff}), LIM1);
            tdy4_in = tiny(mag34({dy1_ff[32], dy1_ff} + {dy2_ff[32], dy2_ff}), LIM4);
            step_in = 1'b0;
            tin_in = '0;
            tout_in = '0;
            state_in = S_PLAN;
         end
         S_PLAN: begin
            if (is_const) begin
               tin_in = TAN_INF;
               tout_in = TAN_INF;
               state_in = S_EMIT;
            end else if (go_div) begin
               quo_in = NW'(num_mag) << FRAC_BITS;
               rem_in = '0;
               den_in = mag34(den);
               neg_in = num[35] ^ den[33];
               cnt_in = CW'(NW / 2);
               state_in = S_DIV;
            end else if (is_lin && !step_ff) begin
               step_in = 1'b1;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_DIV: begin
            rem_in = r1;
            quo_in = q0;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            if (is_lin && !step_ff) begin
               tin_in = sat;
               step_in = 1'b1;
               state_in = S_PLAN;
            end else if (is_lin) begin
               tout_in = sat;
               state_in = S_EMIT;
            end else begin
               tin_in = sat;
               tout_in = sat;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               ov_in = 1'b1;
               od_in = {tout_ff, tin_ff};
               ou_in = {code, code, 1'b1, is_const};
               ol_in = lastj_ff;
               if (!job_ff && q_head.last) begin
                  job_in = 1'b1;
                  state_in = S_DIFF;
               end else begin
                  q_pop = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         job_ff <= 1'b0;
         step_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         job_ff <= job_in;
         step_ff <= step_in;
         ov_ff <= ov_in;
      end
      hp_ff <= hp_in;     hn_ff <= hn_in;     lastj_ff <= lastj_in;
      dx1_ff <= dx1_in;   dy1_ff <= dy1_in;   dx2_ff <= dx2_in;   dy2_ff <= dy2_in;
      dx_ff <= dx_in;     dy_ff <= dy_in;
      tdx1_ff <= tdx1_in; tdx2_ff <= tdx2_in; tdx_ff <= tdx_in;   tdy4_ff <= tdy4_in;
      rem_ff <= rem_in;   quo_ff <= quo_in;   den_ff <= den_in;   neg_ff <= neg_in;
      cnt_ff <= cnt_in;   tin_ff <= tin_in;   tout_ff <= tout_in;
      od_ff <= od_in;     ou_ff <= ou_in;     ol_ff <= ol_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = od_ff;
   assign rsp_tuser = ou_ff;
   assign rsp_tlast = ol_ff;

endmodule
`default_nettype wire

// ===== src/keyframe_tangent_unit.sv =====
// Top level of the keyframe tangent unit.
`timescale 1ns / 1ps
`default_nettype none
// Keyframes enter in curve order; a key's tangents leave once the next key has
// arrived, and the final key of a curve (tlast) releases both pending results.
// A two-entry queue lets the front take keys while the back end works. Each
// quotient runs on one shared restoring divider that retires two bits a cycle.
// A result passes through the setup states (differences, flags, plan), the
// division and fix-up states, and the output state; smooth mode needs at most
// one division, linear mode up to two and constant mode none. A key that
// releases no result is popped from the queue. A final key that follows other
// keys of its curve yields two results.
module keyframe_tangent_unit
   import kft_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wen,
   input  wire logic [1:0]  csr_wdata,   // interp_mode
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // key_time, key_value
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // tan_left, tan_right
   output logic [9:0]       rsp_tuser,   // tangent_infinite, mode_word
   output logic             rsp_tlast
);

   task_type push_task, head;
   logic     q_push, q_ready, q_valid, q_pop;

   kft_front u_front (
      .clock(clock), .reset(reset), .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .q_ready(q_ready), .q_push(q_push), .q_task(push_task)
   );

   kft_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_task(push_task),
      .ready(q_ready), .valid(q_valid), .head(head), .pop(q_pop)
   );

   kft_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_head(head), .q_pop(q_pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   a_const_inf: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 64'h7FFF_FFFF_7FFF_FFFF)
      else $error("infinite tangent word carries finite tangents");

   a_modes_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[1] && rsp_tuser[5:2] == rsp_tuser[9:6])
      else $error("left and right tangent modes differ");

   a_queue_fill: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> q_valid)
      else $error("accepted key did not reach the task queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("task queue popped while empty");

endmodule
`default_nettype wire

// ===== tb/tb_tangent_checker.sv =====
// Checker that predicts keyframe tangents and compares them with the result channel.
`timescale 1ns / 1ps
module tb_tangent_checker
   import kft_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wen,
   input  wire logic [1:0]  csr_wdata,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [63:0] req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [63:0] rsp_tdata,
   input  wire logic [9:0]  rsp_tuser,
   input  wire logic        rsp_tlast,
   output int               fail_count,
   output int               pending_count
);

   typedef struct {
      logic [31:0] tin;
      logic [31:0] tout;
      logic        inf;
      logic [8:0]  mode_word;
      logic        eoc;
   } tangent_word_type;

   tangent_word_type tangent_queue[$];
   logic [1:0] mode_q;
   longint prev_t, prev_v, cur_t, cur_v;
   int window_fill;

   assign pending_count = tangent_queue.size();

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic bit near_zero(longint d, longint scale);
      return mag(d) * 100000 < scale * (longint'(1) << FRAC_BITS);
   endfunction

   function automatic longint fixed_div(longint num, longint den);
      longint q;
      if (near_zero(den, 1)) return 0;
      q = (num * (longint'(1) << FRAC_BITS)) / den;
      if (q > longint'(2147483647)) q = longint'(2147483647);
      if (q < -longint'(2147483647) - 1) q = -longint'(2147483647) - 1;
      return q;
   endfunction

   function automatic int sign_of_slope(longint dy, longint dx);
      int s;
      if (near_zero(dx, 1) || dy == 0) return 0;
      s = dy > 0 ? 1 : -1;
      return dx > 0 ? s : -s;
   endfunction

   function automatic tangent_word_type key_tangents(bit has_prev, longint pt, longint pv,
         longint kt, longint kv, bit has_next, longint nt, longint nv, bit eoc);
      tangent_word_type r;
      logic [3:0] code;
      longint tin, tout, dx1, dy1, dx2, dy2, dx, dy, t;
      int s1, s2;
      tin = 0;
      tout = 0;
      r.inf = 1'b0;
      if (mode_q == MODE_LINEAR) begin
         code = CODE_LINEAR;
         if (has_prev) tin = fixed_div(kv - pv, kt - pt);
         if (has_next) tout = fixed_div(nv - kv, nt - kt);
      end else if (mode_q == MODE_CONST) begin
         code = CODE_CONST;
         tin = TAN_INF;
         tout = TAN_INF;
         r.inf = 1'b1;
      end else begin
         code = CODE_AUTO;
         if (has_prev && has_next) begin
            dx1 = kt - pt; dy1 = kv - pv; dx2 = nt - kt; dy2 = nv - kv;
            dx = dx1 + dx2; dy = dy1 + dy2;
            s1 = sign_of_slope(dy1, dx1);
            s2 = sign_of_slope(dy2, dx2);
            t = 0;
            if (s1 != 0 && s1 == s2) begin
               if (4 * mag(dy1) >= 3 * mag(dy))
                  t = near_zero(dy, 4) ? fixed_div(dy, dx) : fixed_div(4 * dy2, dx);
               else if (4 * mag(dy1) < mag(dy))
                  t = near_zero(dy, 4) ? 0 : fixed_div(4 * dy1, dx);
               else
                  t = fixed_div(dy, dx);
            end
            tin = t;
            tout = t;
         end
      end
      r.tin = tin[31:0];
      r.tout = tout[31:0];
      r.mode_word = {code, code, 1'b1};
      r.eoc = eoc;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      longint kt, kv;
      tangent_word_type w;
      if (reset) begin
         mode_q <= MODE_SMOOTH;
         window_fill = 0;
         prev_t = 0; prev_v = 0; cur_t = 0; cur_v = 0;
         fail_count = 0;
      end else begin
         if (csr_wen) mode_q <= csr_wdata;
         if (req_tvalid && req_tready) begin
            kt = longint'($signed(req_tdata[31:0]));
            kv = longint'($signed(req_tdata[63:32]));
            if (window_fill >= 1) begin
               tangent_queue.push_back(key_tangents(window_fill >= 2, prev_t, prev_v,
                  cur_t, cur_v, 1'b1, kt, kv, 1'b0));
               if (req_tlast)
                  tangent_queue.push_back(key_tangents(1'b1, cur_t, cur_v, kt, kv,
                     1'b0, 0, 0, 1'b1));
            end else if (req_tlast)
               tangent_queue.push_back(key_tangents(1'b0, 0, 0, kt, kv, 1'b0, 0, 0, 1'b1));
            prev_t = cur_t; prev_v = cur_v; cur_t = kt; cur_v = kv;
            if (req_tlast) window_fill = 0;
            else if (window_fill < 2) window_fill++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (tangent_queue.size() == 0) begin
               report_mismatch("unexpected word", 32'd0, 32'd0);
            end else begin
               w = tangent_queue.pop_front();
               if (rsp_tdata[31:0] !== w.tin)
                  report_mismatch("tan_left", rsp_tdata[31:0], w.tin);
               if (rsp_tdata[63:32] !== w.tout)
                  report_mismatch("tan_right", rsp_tdata[63:32], w.tout);
               if (rsp_tuser[0] !== w.inf)
                  report_mismatch("tangent_infinite", 32'(rsp_tuser[0]), 32'(w.inf));
               if (rsp_tuser[9:1] !== w.mode_word)
                  report_mismatch("mode_word", 32'(rsp_tuser[9:1]), 32'(w.mode_word));
               if (rsp_tlast !== w.eoc)
                  report_mismatch("end_of_curve", 32'(rsp_tlast), 32'(w.eoc));
            end
         end
      end
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top that drives keyframes and mode changes into the tangent unit.
`timescale 1ns / 1ps
module tb_top;
   import kft_pkg::*;

   localparam logic [1:0] MODE_SPARE = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic [1:0]  csr_wdata = 2'd0;
   logic        req_tvalid = 1'b0;
   logic [63:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tready = 1'b0;
   wire         req_tready, rsp_tvalid, rsp_tlast;
   wire  [63:0] rsp_tdata;
   wire  [9:0]  rsp_tuser;
   int          fail_count, pending_count;
   int          cycle_count = 0;
   bit          hold_off = 1'b0;

   always #2 clock = ~clock;

   keyframe_tangent_unit dut (.*);
   tb_tangent_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int gap_length();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 80)
                                          : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
   endfunction

   always @(posedge clock) begin
      int n;
      if (reset) rsp_tready <= 1'b0;
      else if (hold_off) rsp_tready <= 1'b0;
      else begin
         rsp_tready <= 1'b1;
         n = gap_length();
         if (n > 0) begin
            @(posedge clock);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_key(logic [31:0] kt, logic [31:0] kv, logic last);
      int n;
      req_tvalid <= 1'b1;
      req_tdata <= {kv, kt};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      n = gap_length();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic set_mode(logic [1:0] m);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic random_curve(int len, bit wild);
      logic [31:0] t, v;
      int i;
      t = $urandom;
      v = $urandom;
      for (i = 0; i < len; i++) begin
         if (wild || $urandom_range(0, 9) == 0) begin
            t = $urandom; v = $urandom;
         end else begin
            t = t + $urandom_range(0, 3) * 32'h10000 + $urandom_range(0, 65535);
            v = v + ($urandom_range(0, 1) ? $urandom_range(0, 32'h40000)
                                          : -$urandom_range(0, 32'h40000));
         end
         send_key(t, v, i == len - 1);
      end
   endtask

   initial begin
      int phase, k;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_key(32'h0, 32'h0, 1'b1);
      send_key(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      send_key(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_key(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_key(32'h0001_0000, 32'h0002_0000, 1'b0);
      send_key(32'h0002_0000, 32'h0004_0000, 1'b0);
      send_key(32'h0003_0000, 32'h0004_8000, 1'b0);
      send_key(32'h0004_0000, 32'h0003_0000, 1'b0);
      send_key(32'h0004_0000, 32'h0001_0000, 1'b0);
      send_key(32'h0005_0000, 32'h0001_0000, 1'b1);
      send_key(32'h0, 32'h0, 1'b0);
      send_key(32'h0, 32'h1, 1'b0);
      send_key(32'h1, 32'h0001_0000, 1'b1);
      for (k = 0; k < 3; k++) begin
         set_mode(k == 0 ? MODE_LINEAR : (k == 1 ? MODE_CONST : MODE_SPARE));
         send_key(32'h0, 32'h0, 1'b1);
         send_key(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
         send_key(32'h8000_0001, 32'h8000_0000, 1'b0);
         send_key(32'h0002_0000, 32'h0004_0000, 1'b1);
      end
      for (phase = 0; phase < 8; phase++) begin
         set_mode(phase % 4 == 1 ? MODE_LINEAR
                                 : (phase % 4 == 2 ? MODE_CONST : MODE_SMOOTH));
         if (phase == 2) begin
            hold_off = 1'b1;
            fork
               begin repeat (400) @(posedge clock); hold_off = 1'b0; end
            join_none
         end
         k = 0;
         while (k < 200) begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            random_curve(len, $urandom_range(0, 7) == 0);
            k += len;
         end
      end
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
